/* hw/rtl/lcwb_pkg.sv */
// shared types, constants and register indexes of the load-cell weigh-and-balance core
package lcwb_pkg;

    localparam int LCWB_DIV_STEPS = 4;    // restoring steps per divider stage
    localparam int LCWB_WDIV_N    = 17;   // magnitude width of a cell weight
    localparam int LCWB_WDIV_D    = 12;   // rounding step width
    localparam int LCWB_BDIV_N    = 26;   // magnitude width of 100 * balance sum
    localparam int LCWB_BDIV_D    = 20;   // magnitude width of the total
    localparam int LCWB_NCELL     = 4;

    localparam logic signed [19:0] LCWB_ERR_TOTAL = -20'sd1028;
    localparam logic signed [19:0] LCWB_NEG_BAND  = -20'sd100;
    localparam logic [6:0]         LCWB_BAL_MAX   = 7'd100;

    typedef enum logic [1:0] {
        MODE_WEIGH    = 2'd0,
        MODE_RADIO    = 2'd1,
        MODE_LINK_ERR = 2'd2,
        MODE_SPARE    = 2'd3
    } t_mode;

    localparam logic [2:0] CFG_FULL_SCALE = 3'd0;
    localparam logic [2:0] CFG_OFFSET     = 3'd1;
    localparam logic [2:0] CFG_STEP       = 3'd2;
    localparam logic [2:0] CFG_MAP_A      = 3'd3;
    localparam logic [2:0] CFG_MAP_B      = 3'd4;
    localparam logic [2:0] CFG_MAP_C      = 3'd5;
    localparam logic [2:0] CFG_MAP_D      = 3'd6;

endpackage

/* hw/rtl/lcwb_div.sv */
// pipelined restoring divider, a few quotient bits per stage, with a sideband carried along
module lcwb_div import lcwb_pkg::*; #(
    parameter int WN  = LCWB_WDIV_N,
    parameter int WD  = LCWB_WDIV_D,
    parameter int WS  = 1,
    parameter int SPS = LCWB_DIV_STEPS
) (
    input  logic          i_clk,
    input  logic [WN-1:0] i_num,
    input  logic [WD-1:0] i_den,
    input  logic [WS-1:0] i_side,
    output logic [WN-1:0] o_quo,
    output logic [WD-1:0] o_rem,
    output logic [WS-1:0] o_side
);

    localparam int NST = (WN + SPS - 1) / SPS;

    // numerator bits shift out of the top, quotient bits shift in at the bottom
    logic [WN-1:0] r_nq   [NST];
    logic [WD-1:0] r_rem  [NST];
    logic [WD-1:0] r_den  [NST];
    logic [WS-1:0] r_side [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [WN-1:0] s_nq;
        logic [WD-1:0] s_rem;
        logic [WD-1:0] s_den;
        logic [WS-1:0] s_side;
        logic [WN-1:0] n_nq;
        logic [WD-1:0] n_rem;

        if (k == 0) begin : g_first
            assign s_nq   = i_num;
            assign s_rem  = '0;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_nq   = r_nq[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_den  = r_den[k-1];
            assign s_side = r_side[k-1];
        end

        always_comb begin
            logic [WD:0] v_rem2;
            logic        v_bit;
            n_nq  = s_nq;
            n_rem = s_rem;
            for (int j = 0; j < SPS; j++) begin
                if (k * SPS + j < WN) begin
                    v_rem2 = {n_rem, n_nq[WN-1]};
                    v_bit  = 1'b0;
                    if (v_rem2 >= {1'b0, s_den}) begin
                        v_rem2 = v_rem2 - {1'b0, s_den};
                        v_bit  = 1'b1;
                    end
                    n_rem = v_rem2[WD-1:0];
                    n_nq  = {n_nq[WN-2:0], v_bit};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_nq[k]   <= n_nq;
            r_rem[k]  <= n_rem;
            r_den[k]  <= s_den;
            r_side[k] <= s_side;
        end
    end

    assign o_quo  = r_nq[NST-1];
    assign o_rem  = r_rem[NST-1];
    assign o_side = r_side[NST-1];

endmodule

/* hw/rtl/lcwb_lane.sv */
// one cell lane: current reading to tared, rounded and saturated weight
module lcwb_lane import lcwb_pkg::*; #(
    parameter int SPS = LCWB_DIV_STEPS
) (
    input  logic               i_clk,
    input  logic [15:0]        i_raw,
    input  logic [15:0]        i_fs,
    input  logic signed [15:0] i_off,
    input  logic [11:0]        i_step,
    output logic signed [17:0] o_weight
);

    // scale is in*fs*20/(16*65535) = (in*fs*5/4)/65535, folded twice by 2^16 == 1 mod 65535
    logic [31:0]        r_prod;
    logic [16:0]        r_q0;
    logic [17:0]        r_t;
    logic [1:0]         r_lo;
    logic [17:0]        r_q;
    logic               r_inex;
    logic signed [19:0] r_w;
    logic signed [17:0] r_weight;

    logic [34:0]        n_n5;
    logic [16:0]        n_r1;
    logic               n_adj;
    logic [16:0]        n_rem;
    logic signed [19:0] n_d;
    logic signed [19:0] n_abs;
    logic signed [17:0] n_weight_p;
    logic [16:0]        div_quo;
    logic [11:0]        div_rem;
    logic [17:0]        div_side;

    assign n_n5  = {3'b0, r_prod} + {1'b0, r_prod, 2'b0};
    assign n_r1  = {1'b0, r_t[15:0]} + {15'b0, r_t[17:16]};
    assign n_adj = (n_r1 >= 17'd65535);
    assign n_rem = n_adj ? n_r1 - 17'd65535 : n_r1;
    assign n_d   = $signed({2'b0, r_q}) - $signed({{4{i_off[15]}}, i_off});
    assign n_abs = (r_w < 0) ? -r_w : r_w;

    always_ff @(posedge i_clk) begin
        r_prod <= i_raw * i_fs;
        r_q0   <= n_n5[34:18];
        r_t    <= {2'b0, n_n5[17:2]} + {1'b0, n_n5[34:18]};
        r_lo   <= n_n5[1:0];
        r_q    <= {1'b0, r_q0} + {16'b0, r_t[17:16]} + {17'b0, n_adj};
        r_inex <= (r_lo != 2'b0) || (n_rem != 17'b0);
        // truncation toward zero pulls an inexact negative value up by one
        r_w    <= n_d + ((n_d < 0 && r_inex) ? 20'sd1 : 20'sd0);
    end

    lcwb_div #(
        .WN (LCWB_WDIV_N),
        .WD (LCWB_WDIV_D),
        .WS (18),
        .SPS(SPS)
    ) u_div (
        .i_clk (i_clk),
        .i_num (n_abs[16:0]),
        .i_den (i_step),
        .i_side(r_w[17:0]),
        .o_quo (div_quo),
        .o_rem (div_rem),
        .o_side(div_side)
    );

    always_comb begin
        logic signed [19:0] v_w;
        logic signed [19:0] v_r;
        logic signed [19:0] v_s;
        logic signed [19:0] v_p;
        v_w = {{2{div_side[17]}}, div_side};
        v_r = $signed({8'b0, div_rem});
        v_s = $signed({8'b0, i_step});
        if (i_step == 12'd0) begin
            v_p = v_w;
        end else begin
            v_p = ({1'b0, div_rem} >= {1'b0, i_step[11:1]} + 13'd0) ? v_w - v_r + v_s
                                                                   : v_w - v_r;
            if (v_p > 0 && v_p <= v_s + 20'sd1) v_p = '0;
            if (v_p < 0 && v_p >= LCWB_NEG_BAND) v_p = '0;
        end
        if (v_p > 20'sd131071) v_p = 20'sd131071;
        if (v_p < -20'sd131072) v_p = -20'sd131072;
        n_weight_p = v_p[17:0];
    end

    always_ff @(posedge i_clk) begin
        r_weight <= n_weight_p ^ {18{div_quo[0] & 1'b0}};
    end

    assign o_weight = r_weight;

endmodule

/* hw/rtl/lcwb_merge.sv */
// merging stage: total of the four lanes and the two balance quotients
module lcwb_merge import lcwb_pkg::*; #(
    parameter int SPS = LCWB_DIV_STEPS
) (
    input  logic               i_clk,
    input  logic signed [17:0] i_weight [LCWB_NCELL],
    output logic signed [19:0] o_total,
    output logic signed [7:0]  o_bal_x,
    output logic signed [7:0]  o_bal_y
);

    logic signed [19:0] r_total;
    logic signed [20:0] r_sx;
    logic signed [20:0] r_sy;
    logic [25:0]        r_nx;
    logic [25:0]        r_ny;
    logic [19:0]        r_den;
    logic               r_negx;
    logic               r_negy;
    logic               r_zero;
    logic signed [19:0] r_total2;
    logic signed [19:0] r_total_o;
    logic signed [7:0]  r_bx;
    logic signed [7:0]  r_by;

    logic signed [20:0] w_a, w_b, w_c, w_d;
    logic signed [20:0] n_ax, n_ay;
    logic signed [19:0] n_at;
    logic [25:0]        qx, qy;
    logic [19:0]        rx, ry;
    logic [21:0]        sidex;
    logic [1:0]         sidey;

    assign w_a = 21'(i_weight[0]);
    assign w_b = 21'(i_weight[1]);
    assign w_c = 21'(i_weight[2]);
    assign w_d = 21'(i_weight[3]);

    assign n_ax = (r_sx < 0) ? -r_sx : r_sx;
    assign n_ay = (r_sy < 0) ? -r_sy : r_sy;
    assign n_at = (r_total < 0) ? -r_total : r_total;

    always_ff @(posedge i_clk) begin
        r_total  <= 20'(w_a + w_b + w_c + w_d);
        r_sx     <= w_a - w_b - w_c + w_d;
        r_sy     <= w_a + w_b - w_c - w_d;
        r_nx     <= {6'b0, n_ax[19:0]} * 26'd100;
        r_ny     <= {6'b0, n_ay[19:0]} * 26'd100;
        r_den    <= n_at;
        r_negx   <= r_sx[20] ^ r_total[19];
        r_negy   <= r_sy[20] ^ r_total[19];
        r_zero   <= (r_total == 20'sd0);
        r_total2 <= r_total;
    end

    lcwb_div #(
        .WN (LCWB_BDIV_N),
        .WD (LCWB_BDIV_D),
        .WS (22),
        .SPS(SPS)
    ) u_div_x (
        .i_clk (i_clk),
        .i_num (r_nx),
        .i_den (r_den),
        .i_side({r_total2, r_zero, r_negx}),
        .o_quo (qx),
        .o_rem (rx),
        .o_side(sidex)
    );

    lcwb_div #(
        .WN (LCWB_BDIV_N),
        .WD (LCWB_BDIV_D),
        .WS (2),
        .SPS(SPS)
    ) u_div_y (
        .i_clk (i_clk),
        .i_num (r_ny),
        .i_den (r_den),
        .i_side({r_zero, r_negy}),
        .o_quo (qy),
        .o_rem (ry),
        .o_side(sidey)
    );

    function automatic logic signed [7:0] bal_fix(input logic [25:0] q, input logic zero,
                                                 input logic neg);
        logic [7:0] v_m;
        begin
            v_m = (q > 26'd100) ? {1'b0, LCWB_BAL_MAX} : q[7:0];
            if (zero) bal_fix = '0;
            else if (neg) bal_fix = -$signed(v_m);
            else bal_fix = $signed(v_m);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        r_total_o <= $signed(sidex[21:2]);
        r_bx      <= bal_fix(qx, sidex[1], sidex[0]) | {8{rx[0] & 1'b0}};
        r_by      <= bal_fix(qy, sidey[1], sidey[0]) | {8{ry[0] & 1'b0}};
    end

    assign o_total = r_total_o;
    assign o_bal_x = r_bx;
    assign o_bal_y = r_by;

endmodule

/* hw/rtl/load_cell_weigh_and_balance_core.sv */
// top level of the load-cell weigh-and-balance core
//
// command channel: an item (mode and four readings) is taken at every edge
// with i_start high; o_busy stays low, so a new item may follow every cycle
// result channel: o_done marks each result for exactly one cycle and the
// receiver has no way to hold it off; results leave in the order taken
// the pipeline holds 1 remap stage, a cell lane of 5 + ceil(17/DIV_STEPS)
// stages, a merging stage of 3 + ceil(26/DIV_STEPS) stages and the output register
// throughput is one item per cycle; the depth is set by the restoring
// dividers of the rounding remainder and of the two balance quotients
// for configuration, i_cfg_we writes register i_cfg_idx at once; the user
// must write only while idle, as the core itself does not enforce it
// reset (synchronous, active low) clears the configuration registers, the
// valid delay line and o_done, and drops items in flight
module load_cell_weigh_and_balance_core import lcwb_pkg::*; #(
    parameter int DIV_STEPS = LCWB_DIV_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_word_a,
    input  logic [15:0]        i_word_b,
    input  logic [15:0]        i_word_c,
    input  logic [15:0]        i_word_d,
    output logic               o_done,
    output logic               o_result_code,
    output logic               o_master_ok,
    output logic               o_radio_ok,
    output logic signed [17:0] o_weight_a,
    output logic signed [17:0] o_weight_b,
    output logic signed [17:0] o_weight_c,
    output logic signed [17:0] o_weight_d,
    output logic signed [19:0] o_total_weight,
    output logic signed [7:0]  o_balance_x,
    output logic signed [7:0]  o_balance_y
);

    // pipeline depths follow from the divider stage width
    localparam int LANE_LAT  = 5 + (LCWB_WDIV_N + DIV_STEPS - 1) / DIV_STEPS;
    localparam int MERGE_LAT = 3 + (LCWB_BDIV_N + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DLY       = LANE_LAT + MERGE_LAT + 1;

    // configuration registers
    logic [15:0]        r_fs;
    logic signed [15:0] r_off;
    logic [11:0]        r_step;
    logic [2:0]         r_map [LCWB_NCELL];

    // remap stage and control delay line
    logic [15:0]        r_cell [LCWB_NCELL];
    logic               r_dv    [DLY];
    t_mode              r_dmode [DLY];
    logic               r_dradio[DLY];

    // output registers
    logic               r_done;
    logic               r_result_code;
    logic               r_master_ok;
    logic               r_radio_ok;
    logic signed [17:0] r_wt [LCWB_NCELL];
    logic signed [19:0] r_total;
    logic signed [7:0]  r_bx;
    logic signed [7:0]  r_by;

    logic [15:0]        n_words [LCWB_NCELL];
    logic [15:0]        n_cell  [LCWB_NCELL];
    logic signed [17:0] lane_w  [LCWB_NCELL];
    logic signed [19:0] m_total;
    logic signed [7:0]  m_bx;
    logic signed [7:0]  m_by;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs   <= '0;
            r_off  <= '0;
            r_step <= '0;
            for (int i = 0; i < LCWB_NCELL; i++) r_map[i] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FULL_SCALE: r_fs     <= i_cfg_data;
                CFG_OFFSET:     r_off    <= $signed(i_cfg_data);
                CFG_STEP:       r_step   <= i_cfg_data[11:0];
                CFG_MAP_A:      r_map[0] <= i_cfg_data[2:0];
                CFG_MAP_B:      r_map[1] <= i_cfg_data[2:0];
                CFG_MAP_C:      r_map[2] <= i_cfg_data[2:0];
                CFG_MAP_D:      r_map[3] <= i_cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // channel remap, all cells choose among the original words
    assign n_words[0] = i_word_a;
    assign n_words[1] = i_word_b;
    assign n_words[2] = i_word_c;
    assign n_words[3] = i_word_d;

    always_comb begin
        logic [2:0] v_sel;
        for (int i = 0; i < LCWB_NCELL; i++) begin
            v_sel = r_map[i] - 3'd1;
            if (r_map[i] inside {[3'd1:3'd4]}) begin
                n_cell[i] = n_words[v_sel[1:0]];
            end else begin
                n_cell[i] = n_words[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LCWB_NCELL; i++) r_cell[i] <= n_cell[i];
    end

    // control travels beside the lanes, one tap per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) r_dv[k] <= 1'b0;
        end else begin
            r_dv[0] <= i_start & ~o_busy;
            for (int k = 1; k < DLY; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmode[0]  <= t_mode'(i_mode);
        r_dradio[0] <= (i_word_a != 16'd0);
        for (int k = 1; k < DLY; k++) begin
            r_dmode[k]  <= r_dmode[k-1];
            r_dradio[k] <= r_dradio[k-1];
        end
    end

    // four cell lanes side by side
    for (genvar g = 0; g < LCWB_NCELL; g++) begin : g_lane
        lcwb_lane #(
            .SPS(DIV_STEPS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_raw   (r_cell[g]),
            .i_fs    (r_fs),
            .i_off   (r_off),
            .i_step  (r_step),
            .o_weight(lane_w[g])
        );
    end

    lcwb_merge #(
        .SPS(DIV_STEPS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_weight(lane_w),
        .o_total (m_total),
        .o_bal_x (m_bx),
        .o_bal_y (m_by)
    );

    // weights of the lanes are aligned with the merge outputs
    logic signed [17:0] r_wdly [LCWB_NCELL][MERGE_LAT];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LCWB_NCELL; i++) begin
            r_wdly[i][0] <= lane_w[i];
            for (int k = 1; k < MERGE_LAT; k++) r_wdly[i][k] <= r_wdly[i][k-1];
        end
    end

    // result selection by frame mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result_code <= 1'b1;
        r_master_ok   <= 1'b0;
        r_radio_ok    <= 1'b0;
        r_total       <= '0;
        r_bx          <= '0;
        r_by          <= '0;
        for (int i = 0; i < LCWB_NCELL; i++) r_wt[i] <= '0;
        case (r_dmode[DLY-1])
            MODE_WEIGH: begin
                r_result_code <= (m_total == LCWB_ERR_TOTAL);
                r_master_ok   <= 1'b1;
                r_total       <= m_total;
                r_bx          <= m_bx;
                r_by          <= m_by;
                for (int i = 0; i < LCWB_NCELL; i++) r_wt[i] <= r_wdly[i][MERGE_LAT-1];
            end
            MODE_RADIO: begin
                r_master_ok <= 1'b1;
                r_radio_ok  <= r_dradio[DLY-1];
            end
            default: ;
        endcase
    end

    assign o_done         = r_done;
    assign o_result_code  = r_result_code;
    assign o_master_ok    = r_master_ok;
    assign o_radio_ok     = r_radio_ok;
    assign o_weight_a     = r_wt[0];
    assign o_weight_b     = r_wt[1];
    assign o_weight_c     = r_wt[2];
    assign o_weight_d     = r_wt[3];
    assign o_total_weight = r_total;
    assign o_balance_x    = r_bx;
    assign o_balance_y    = r_by;

endmodule
